// ===== hdl/ptd_pkg.sv =====
// Shared types, constants and microcode for the trial-division prime classifier.
// Uses no other file.
`default_nettype none

package ptd_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int MAX_ITEMS_DEF   = 65536;
    localparam int SLOT_WIDTH      = 16;
    localparam int UPC_WIDTH       = 4;
    localparam int COND_WIDTH      = 3;

    typedef logic [UPC_WIDTH-1:0]  upc_t;
    typedef logic [COND_WIDTH-1:0] cond_t;

    // Microprogram addresses
    localparam upc_t STEP_IDLE   = 4'd0;
    localparam upc_t STEP_SCREEN = 4'd1;
    localparam upc_t STEP_SQ     = 4'd2;
    localparam upc_t STEP_CMP    = 4'd3;
    localparam upc_t STEP_DINIT  = 4'd4;
    localparam upc_t STEP_DSTEP  = 4'd5;
    localparam upc_t STEP_TEST   = 4'd6;
    localparam upc_t STEP_NEXTD  = 4'd7;
    localparam upc_t STEP_PRIME  = 4'd8;
    localparam upc_t STEP_NOTP   = 4'd9;
    localparam upc_t STEP_EMIT   = 4'd10;
    localparam upc_t STEP_RET    = 4'd11;

    // Jump conditions; when true go to target, else fall through
    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_ALWAYS   = 3'd1;
    localparam cond_t COND_NO_IN    = 3'd2;
    localparam cond_t COND_SMALL    = 3'd3;
    localparam cond_t COND_SQ_GT    = 3'd4;
    localparam cond_t COND_DIV_MORE = 3'd5;
    localparam cond_t COND_REM_ZERO = 3'd6;
    localparam cond_t COND_OUT_BUSY = 3'd7;

    typedef struct packed {
        upc_t  target;
        cond_t cond;
        logic  ld_in;
        logic  sq_ld;
        logic  div_init;
        logic  div_step;
        logic  d_inc;
        logic  set_prime;
        logic  clr_prime;
        logic  emit;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input upc_t addr);
        ctrl_t cw;
        begin
            cw = '0;
            cw.target = STEP_IDLE;
            cw.cond   = COND_NEVER;
            unique case (addr)
                STEP_IDLE: begin
                    cw.ld_in = 1'b1; cw.cond = COND_NO_IN; cw.target = STEP_IDLE;
                end
                STEP_SCREEN: begin
                    cw.cond = COND_SMALL; cw.target = STEP_NOTP;
                end
                STEP_SQ: begin
                    cw.sq_ld = 1'b1;
                end
                STEP_CMP: begin
                    cw.cond = COND_SQ_GT; cw.target = STEP_PRIME;
                end
                STEP_DINIT: begin
                    cw.div_init = 1'b1;
                end
                STEP_DSTEP: begin
                    cw.div_step = 1'b1; cw.cond = COND_DIV_MORE; cw.target = STEP_DSTEP;
                end
                STEP_TEST: begin
                    cw.cond = COND_REM_ZERO; cw.target = STEP_NOTP;
                end
                STEP_NEXTD: begin
                    cw.d_inc = 1'b1; cw.cond = COND_ALWAYS; cw.target = STEP_SQ;
                end
                STEP_PRIME: begin
                    cw.set_prime = 1'b1; cw.cond = COND_ALWAYS; cw.target = STEP_EMIT;
                end
                STEP_NOTP: begin
                    cw.clr_prime = 1'b1;
                end
                STEP_EMIT: begin
                    cw.emit = 1'b1; cw.cond = COND_OUT_BUSY; cw.target = STEP_EMIT;
                end
                STEP_RET: begin
                    cw.cond = COND_ALWAYS; cw.target = STEP_IDLE;
                end
                default: begin
                    cw.cond = COND_ALWAYS; cw.target = STEP_IDLE;
                end
            endcase
            return cw;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/prime_partition_trial_division.sv =====
// Top level of the trial-division prime classifier: microcode sequencer and datapath.
// Depends on ptd_pkg (control word, microprogram table, constants).
`default_nettype none

// One value is taken per beat and tested by trial division with divisors
// d = 2, 3, ... while d*d <= value; each candidate passes the squaring and
// compare steps, the bit-serial remainder unit (one quotient bit per cycle)
// and the test step. Negative values, 0 and 1 go straight to the not-prime
// step. One item is in work at a time; the result register lets the next
// value be accepted while a result waits.
// m_tdata holds value_out then slot; m_tuser holds the prime flag. Slot counters
// saturate at min(MAX_ITEMS-1, 65535) and clear after a beat with tlast set.
module prime_partition_trial_division
    import ptd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,   // value
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [((VALUE_WIDTH+SLOT_WIDTH+7)/8)*8-1:0] m_tdata,   // value_out, slot
    output logic [0:0]                                  m_tuser,   // prime_flag
    output logic                                        m_tlast
);

    localparam int VW       = VALUE_WIDTH;
    localparam int CNT_W    = $clog2(VW + 1);
    localparam int SLOT_CAP = (MAX_ITEMS - 1 < 65535) ? MAX_ITEMS - 1 : 65535;
    localparam logic [SLOT_WIDTH-1:0] SLOT_MAX = SLOT_CAP[SLOT_WIDTH-1:0];

    upc_t  upc_reg, upc_next;
    ctrl_t cw;
    logic  jump;

    logic [VW-1:0]         val_reg;
    logic                  last_reg;
    logic [VW-1:0]         d_reg;
    logic [2*VW-1:0]       sq_reg;
    logic [VW:0]           rem_reg;
    logic [VW-1:0]         shr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  prime_reg;
    logic [SLOT_WIDTH-1:0] ptot_reg, nptot_reg;

    logic                  m_valid_reg;
    logic [VW-1:0]         m_val_reg;
    logic [SLOT_WIDTH-1:0] m_slot_reg;
    logic                  m_prime_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic [VW+1:0]         trial;
    logic [SLOT_WIDTH-1:0] slot_sel;

    assign cw       = ucode_rom(upc_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (upc_reg == STEP_IDLE);
    assign trial    = {rem_reg, shr_reg[VW-1]};
    assign slot_sel = prime_reg ? ptot_reg : nptot_reg;

    always_comb begin
        case (cw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_IN:    jump = !s_tvalid;
            COND_SMALL:    jump = val_reg[VW-1] || (val_reg < VW'(2));
            COND_SQ_GT:    jump = sq_reg > {{VW{1'b0}}, val_reg};
            COND_DIV_MORE: jump = (cnt_reg != CNT_W'(1));
            COND_REM_ZERO: jump = (rem_reg == '0);
            COND_OUT_BUSY: jump = !out_free;
            default:       jump = 1'b0;
        endcase
        upc_next = jump ? cw.target : upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= STEP_IDLE;
            m_valid_reg <= 1'b0;
            ptot_reg    <= '0;
            nptot_reg   <= '0;
        end else begin
            upc_reg <= upc_next;
            if (m_tready)
                m_valid_reg <= 1'b0;
            if (cw.emit && out_free) begin
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    ptot_reg  <= '0;
                    nptot_reg <= '0;
                end else if (prime_reg) begin
                    ptot_reg <= (ptot_reg < SLOT_MAX) ? ptot_reg + 1'b1 : SLOT_MAX;
                end else begin
                    nptot_reg <= (nptot_reg < SLOT_MAX) ? nptot_reg + 1'b1 : SLOT_MAX;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.ld_in && s_tvalid) begin
            val_reg  <= s_tdata[VW-1:0];
            last_reg <= s_tlast;
            d_reg    <= VW'(2);
        end
        if (cw.sq_ld)
            sq_reg <= d_reg * d_reg;
        if (cw.div_init) begin
            rem_reg <= '0;
            shr_reg <= val_reg;
            cnt_reg <= CNT_W'(VW);
        end
        if (cw.div_step) begin
            if (trial >= {2'b00, d_reg})
                rem_reg <= (VW+1)'(trial - {2'b00, d_reg});
            else
                rem_reg <= trial[VW:0];
            shr_reg <= {shr_reg[VW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cw.d_inc)
            d_reg <= d_reg + 1'b1;
        if (cw.set_prime)
            prime_reg <= 1'b1;
        if (cw.clr_prime)
            prime_reg <= 1'b0;
        if (cw.emit && out_free) begin
            m_val_reg   <= val_reg;
            m_slot_reg  <= slot_sel;
            m_prime_reg <= prime_reg;
            m_last_reg  <= last_reg;
        end
    end

    always_comb begin
        m_tdata                     = '0;
        m_tdata[VW-1:0]             = m_val_reg;
        m_tdata[VW+SLOT_WIDTH-1:VW] = m_slot_reg;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_prime_reg;
    assign m_tlast    = m_last_reg;

endmodule

`default_nettype wire
